// ----- rtl/core/frs_pkg.sv -----
// Shared constants, request codes and payload types of the roulette selector.
// Depends on nothing; the top level uses it by scoped names.
package frs_pkg;

   // Sizing of the population store and of the request fields
   localparam int MAX_ENTRIES  = 64;
   localparam int FITNESS_BITS = 16;
   localparam int RAND_BITS    = 16;

   // Derived widths
   localparam int IDX_W    = $clog2(MAX_ENTRIES);
   localparam int CNT_W    = $clog2(MAX_ENTRIES + 1);
   localparam int TOTAL_W  = FITNESS_BITS + IDX_W;
   localparam int WEIGHT_W = FITNESS_BITS + 1;
   localparam int WHEEL_W  = WEIGHT_W + IDX_W;
   localparam int MUL_B_W  = (RAND_BITS > CNT_W) ? RAND_BITS : CNT_W;
   localparam int PROD_W   = WHEEL_W + MUL_B_W;

   // Q9.8 value of 1.0
   localparam logic [WEIGHT_W-1:0] Q_ONE = WEIGHT_W'(256);

   // Request codes
   localparam logic [1:0] REQ_CLEAR  = 2'd0;
   localparam logic [1:0] REQ_APPEND = 2'd1;
   localparam logic [1:0] REQ_SELECT = 2'd2;

   typedef struct packed {
      logic [1:0]              req_type;
      logic [FITNESS_BITS-1:0] fitness_value;
      logic                    pick_lowest;
      logic [RAND_BITS-1:0]    rand_fraction;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] chosen_index;
      logic             no_pick;
   } rsp_type;

endpackage

// ----- rtl/core/frs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; holds the fitness population of the selector.
module frs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write on enable, read every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/fitness_roulette_select.sv -----
// Roulette wheel selection engine: population store, running sum and peak.
// Depends on frs_pkg and frs_ram.
//
// Usage:
//   req channel (req_valid/req_ready/req_data) takes clear, append and select
//   requests. rsp channel (rsp_valid/rsp_ready/rsp_data) returns one result for
//   each select request and nothing for the other codes.
//   Clear and append are done on acceptance; they are accepted even while a
//   result waits in the output register.
//   A select on an empty population goes straight to ST_FINISH with no_pick.
//   A select in normal mode passes ST_SCALE, ST_TARGET and ST_WALK before
//   ST_FINISH loads the result; inverse mode first adds ST_MUL_INV and ST_SUB
//   for the wheel-total multiply and subtract. One entry of the walk is
//   read from the RAM and accumulated per cycle. One multiplier serves the
//   inverse-total product and the target scaling in turn.
//   req_ready is low from a select's acceptance until its result is loaded.
//   If the receiver stalls, the finished result waits in the output register
//   and the next select holds its own result until that one is taken.
//   Reset empties the population and drops any result in flight.
module fitness_roulette_select (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  frs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output frs_pkg::rsp_type rsp_data
);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_MUL_INV = 3'd1;
   localparam logic [2:0] ST_SUB     = 3'd2;
   localparam logic [2:0] ST_SCALE   = 3'd3;
   localparam logic [2:0] ST_TARGET  = 3'd4;
   localparam logic [2:0] ST_WALK    = 3'd5;
   localparam logic [2:0] ST_FINISH  = 3'd6;

   logic [2:0]                       state_ff, state_in;
   logic [frs_pkg::CNT_W-1:0]        count_ff, count_in;
   logic [frs_pkg::TOTAL_W-1:0]      total_ff, total_in;
   logic [frs_pkg::FITNESS_BITS-1:0] peak_ff, peak_in;
   logic                             inverse_ff, inverse_in;
   logic [frs_pkg::RAND_BITS-1:0]    rand_ff, rand_in;
   logic [frs_pkg::WHEEL_W-1:0]      wheel_ff, wheel_in;
   logic [frs_pkg::PROD_W-1:0]       prod_ff, prod_in;
   logic [frs_pkg::WHEEL_W-1:0]      target_ff, target_in;
   logic [frs_pkg::WHEEL_W-1:0]      acc_ff, acc_in;
   logic [frs_pkg::IDX_W-1:0]        walk_idx_ff, walk_idx_in;
   logic [frs_pkg::IDX_W-1:0]        res_idx_ff, res_idx_in;
   logic                             res_none_ff, res_none_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   frs_pkg::rsp_type                 rsp_data_ff, rsp_data_in;

   logic                             req_fire;
   logic                             out_free;
   logic                             ram_wr_en;
   logic [frs_pkg::IDX_W-1:0]        ram_rd_addr;
   logic [frs_pkg::FITNESS_BITS-1:0] ram_rd_data;
   logic [frs_pkg::WHEEL_W-1:0]      mul_a;
   logic [frs_pkg::MUL_B_W-1:0]      mul_b;
   logic [frs_pkg::PROD_W-1:0]       mul_prod;
   logic [frs_pkg::WEIGHT_W-1:0]     weight;
   logic [frs_pkg::WHEEL_W-1:0]      acc_sum;
   logic                             walk_last;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Population store
   assign ram_wr_en = req_fire && (req_data.req_type == frs_pkg::REQ_APPEND)
                      && (count_ff < frs_pkg::CNT_W'(frs_pkg::MAX_ENTRIES));
   assign ram_rd_addr = (state_ff == ST_WALK) ? (walk_idx_ff + 1'b1) : '0;

   frs_ram #(
      .WIDTH (frs_pkg::FITNESS_BITS),
      .DEPTH (frs_pkg::MAX_ENTRIES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[frs_pkg::IDX_W-1:0]),
      .wr_data (req_data.fitness_value),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Shared multiplier: inverse wheel total first, target scaling second
   always_comb begin
      if (state_ff == ST_MUL_INV) begin
         mul_a = frs_pkg::WHEEL_W'({1'b0, peak_ff} + frs_pkg::Q_ONE);
         mul_b = frs_pkg::MUL_B_W'(count_ff);
      end else begin
         mul_a = wheel_ff;
         mul_b = frs_pkg::MUL_B_W'(rand_ff);
      end
   end

   assign mul_prod = mul_a * mul_b;

   // Weight of the entry under the walk, and the running prefix sum
   assign weight = inverse_ff
      ? ({1'b0, peak_ff} + frs_pkg::Q_ONE - {1'b0, ram_rd_data})
      : {1'b0, ram_rd_data};
   assign acc_sum   = acc_ff + frs_pkg::WHEEL_W'(weight);
   assign walk_last = (frs_pkg::CNT_W'(walk_idx_ff) + 1'b1) == count_ff;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      peak_in      = peak_ff;
      inverse_in   = inverse_ff;
      rand_in      = rand_ff;
      wheel_in     = wheel_ff;
      prod_in      = prod_ff;
      target_in    = target_ff;
      acc_in       = acc_ff;
      walk_idx_in  = walk_idx_ff;
      res_idx_in   = res_idx_ff;
      res_none_in  = res_none_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               inverse_in = req_data.pick_lowest;
               rand_in    = req_data.rand_fraction;
               case (req_data.req_type)
                  frs_pkg::REQ_CLEAR: begin
                     count_in = '0;
                     total_in = '0;
                     peak_in  = '0;
                  end
                  frs_pkg::REQ_APPEND: begin
                     if (ram_wr_en) begin
                        count_in = count_ff + 1'b1;
                        total_in = total_ff
                                   + frs_pkg::TOTAL_W'(req_data.fitness_value);
                        if (req_data.fitness_value > peak_ff) begin
                           peak_in = req_data.fitness_value;
                        end
                     end
                  end
                  frs_pkg::REQ_SELECT: begin
                     res_idx_in  = '0;
                     res_none_in = 1'b1;
                     wheel_in    = frs_pkg::WHEEL_W'(total_ff);
                     if (count_ff == '0) begin
                        state_in = ST_FINISH;
                     end else if (req_data.pick_lowest) begin
                        state_in = ST_MUL_INV;
                     end else begin
                        state_in = ST_SCALE;
                     end
                  end
                  default: begin
                     // unused code: drop
                  end
               endcase
            end
         end
         ST_MUL_INV: begin
            prod_in  = mul_prod;
            state_in = ST_SUB;
         end
         ST_SUB: begin
            wheel_in = prod_ff[frs_pkg::WHEEL_W-1:0]
                       - frs_pkg::WHEEL_W'(total_ff);
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            prod_in  = mul_prod;
            state_in = ST_TARGET;
         end
         ST_TARGET: begin
            target_in   = prod_ff[frs_pkg::RAND_BITS +: frs_pkg::WHEEL_W];
            acc_in      = '0;
            walk_idx_in = '0;
            state_in    = ST_WALK;
         end
         ST_WALK: begin
            acc_in = acc_sum;
            if (acc_sum >= target_ff) begin
               res_idx_in  = walk_idx_ff;
               res_none_in = 1'b0;
               state_in    = ST_FINISH;
            end else if (walk_last) begin
               state_in = ST_FINISH;
            end else begin
               walk_idx_in = walk_idx_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            // hold the result until the output register is free
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.chosen_index = res_idx_ff;
               rsp_data_in.no_pick      = res_none_ff;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         peak_ff      <= peak_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      inverse_ff  <= inverse_in;
      rand_ff     <= rand_in;
      wheel_ff    <= wheel_in;
      prod_ff     <= prod_in;
      target_ff   <= target_in;
      acc_ff      <= acc_in;
      walk_idx_ff <= walk_idx_in;
      res_idx_ff  <= res_idx_in;
      res_none_ff <= res_none_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= frs_pkg::CNT_W'(frs_pkg::MAX_ENTRIES))
      else $error("population count exceeds capacity");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (frs_pkg::CNT_W'(walk_idx_ff) < count_ff))
      else $error("walk index beyond population");

   a_no_pick_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.no_pick) |-> (rsp_data_ff.chosen_index == '0))
      else $error("no_pick result carries a nonzero index");

   a_empty_select: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_data.req_type == frs_pkg::REQ_SELECT) && (count_ff == '0))
      |=> (state_ff == ST_FINISH) && res_none_ff)
      else $error("empty select did not flag no_pick");

endmodule
